[hw/rtl/bdqs_pkg.sv]
package bdqs_pkg;

   // Command codes
   localparam logic [3:0] CMD_APPEND    = 4'd0;
   localparam logic [3:0] CMD_PREPEND   = 4'd1;
   localparam logic [3:0] CMD_POP_LAST  = 4'd2;
   localparam logic [3:0] CMD_POP_FIRST = 4'd3;
   localparam logic [3:0] CMD_GET       = 4'd4;
   localparam logic [3:0] CMD_FIND      = 4'd5;
   localparam logic [3:0] CMD_COUNT     = 4'd6;
   localparam logic [3:0] CMD_MIN       = 4'd7;
   localparam logic [3:0] CMD_MAX       = 4'd8;
   localparam logic [3:0] CMD_CLEAR     = 4'd9;

   // Status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_EMPTY     = 3'd1;
   localparam logic [2:0] STS_RANGE     = 3'd2;
   localparam logic [2:0] STS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STS_FULL      = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Flags from the shared compare unit
   typedef struct packed {
      logic eq;
      logic lt;
      logic gt;
   } cmp_type;

endpackage

[hw/rtl/bdqs_if.sv]
// Command channel
interface bdqs_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         command;
   logic signed [31:0] value;
   logic [3:0]         position;

   modport source (output valid, output command, output value, output position, input ready);
   modport sink   (input valid, input command, input value, input position, output ready);
endinterface

// Result channel
interface bdqs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [3:0]         result_position;
   logic [4:0]         match_count;
   logic [4:0]         occupancy;
   logic [2:0]         status;

   modport source (output valid, output result_value, output result_position,
                   output match_count, output occupancy, output status, input ready);
   modport sink   (input valid, input result_value, input result_position,
                   input match_count, input occupancy, input status, output ready);
endinterface

[hw/rtl/bdqs_cmp_unit.sv]
module bdqs_cmp_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic [DATA_WIDTH-1:0] lhs,
   input  logic [DATA_WIDTH-1:0] rhs,
   output bdqs_pkg::cmp_type     result
);
   import bdqs_pkg::*;

   // Equality and signed order of one stored entry against the operand
   always_comb begin
      result.eq = (lhs == rhs);
      result.lt = ($signed(lhs) < $signed(rhs));
      result.gt = ($signed(lhs) > $signed(rhs));
   end

endmodule

[hw/rtl/bounded_deque_with_search_top.sv]
// Channel   Dir  Payload                                                  Transfer
// req_ch    in   command, value, position                                 valid & ready
// rsp_ch    out  result_value, result_position, match_count,              valid & ready
//                occupancy, status
//
// Append, prepend, clear and unused codes go from EXEC to DONE, then to the output register;
// pop and get add a READ state for the single registered read port of the entry RAM.
// Find, count, min and max stream held entries through that port and the one
// compare unit in the SCAN state (find stops at the first match).
// Reset clears the front pointer and the count; the entry RAM needs no clearing.
// A result waits in the output register while the next command is accepted.
module bounded_deque_with_search_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   bdqs_req_if.sink    req_ch,
   bdqs_rsp_if.source  rsp_ch
);
   import bdqs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int GW = (CW > 4) ? CW : 4;
   localparam logic [PW-1:0] LAST_ADDR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // Ring address of front plus offset, one wrap at most
   function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [CW-1:0] offs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offs);
      if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
      return sum[PW-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [3:0]            cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] query_ff, query_in;
   logic [3:0]            pos_ff, pos_in;
   logic [PW-1:0]         front_ff, front_in;
   logic [CW-1:0]         held_ff, held_in;
   logic [PW-1:0]         scan_addr_ff, scan_addr_in;
   logic [CW-1:0]         issue_idx_ff, issue_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [DATA_WIDTH-1:0] best_ff, best_in;
   logic [PW-1:0]         res_pos_ff, res_pos_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [2:0]            status_ff, status_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_value_ff, out_value_in;
   logic [3:0]            out_pos_ff, out_pos_in;
   logic [4:0]            out_count_ff, out_count_in;
   logic [4:0]            out_occ_ff, out_occ_in;
   logic [2:0]            out_status_ff, out_status_in;

   logic                  mem_we, mem_re;
   logic [PW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [DATA_WIDTH-1:0] cmp_rhs;
   cmp_type               cmp_res;
   logic [63:0]           wide_value;
   logic [63:0]           wide_query;
   logic                  is_query_cmd;
   logic                  take_best;

   // Entry RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   // Shared compare unit
   assign is_query_cmd = (cmd_ff == CMD_FIND) || (cmd_ff == CMD_COUNT);
   assign cmp_rhs      = is_query_cmd ? query_ff : best_ff;

   bdqs_cmp_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_cmp (
      .lhs    (rd_data_ff),
      .rhs    (cmp_rhs),
      .result (cmp_res)
   );

   // Width conversions of input query and output value
   assign wide_query = 64'(req_ch.value);
   assign wide_value = 64'($signed(best_ff));

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      query_in      = query_ff;
      pos_in        = pos_ff;
      front_in      = front_ff;
      held_in       = held_ff;
      scan_addr_in  = scan_addr_ff;
      issue_idx_in  = issue_idx_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_in       = best_ff;
      res_pos_in    = res_pos_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff & ~rsp_ch.ready;
      out_value_in  = out_value_ff;
      out_pos_in    = out_pos_ff;
      out_count_in  = out_count_ff;
      out_occ_in    = out_occ_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = ring_add(front_ff, held_ff);
      mem_wdata     = query_ff;
      mem_re        = 1'b0;
      mem_raddr     = scan_addr_ff;
      take_best     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in     = req_ch.command;
               query_in   = wide_query[DATA_WIDTH-1:0];
               pos_in     = req_ch.position;
               best_in    = '0;
               res_pos_in = '0;
               count_in   = '0;
               status_in  = STS_OK;
               state_in   = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (cmd_ff)
               CMD_APPEND: begin
                  if (held_ff == FULL_COUNT) begin
                     status_in = STS_FULL;
                  end else begin
                     mem_we  = 1'b1;
                     held_in = held_ff + 1'b1;
                  end
               end
               CMD_PREPEND: begin
                  if (held_ff == FULL_COUNT) begin
                     status_in = STS_FULL;
                  end else begin
                     front_in  = (front_ff == '0) ? LAST_ADDR : front_ff - 1'b1;
                     mem_we    = 1'b1;
                     mem_waddr = front_in;
                     held_in   = held_ff + 1'b1;
                  end
               end
               CMD_POP_LAST: begin
                  if (held_ff == '0) begin
                     status_in = STS_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = ring_add(front_ff, held_ff - 1'b1);
                     held_in   = held_ff - 1'b1;
                     state_in  = ST_READ;
                  end
               end
               CMD_POP_FIRST: begin
                  if (held_ff == '0) begin
                     status_in = STS_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = front_ff;
                     front_in  = (front_ff == LAST_ADDR) ? '0 : front_ff + 1'b1;
                     held_in   = held_ff - 1'b1;
                     state_in  = ST_READ;
                  end
               end
               CMD_GET: begin
                  if (held_ff == '0) begin
                     status_in = STS_EMPTY;
                  end else if (GW'(pos_ff) >= GW'(held_ff)) begin
                     status_in = STS_RANGE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = ring_add(front_ff, CW'(pos_ff));
                     state_in  = ST_READ;
                  end
               end
               CMD_FIND, CMD_COUNT, CMD_MIN, CMD_MAX: begin
                  if (cmd_ff == CMD_FIND) begin
                     status_in = STS_NOT_FOUND;
                  end else if (held_ff == '0 && cmd_ff != CMD_COUNT) begin
                     status_in = STS_EMPTY;
                  end
                  if (held_ff != '0) begin
                     scan_addr_in = front_ff;
                     issue_idx_in = '0;
                     state_in     = ST_SCAN;
                  end
               end
               CMD_CLEAR: begin
                  held_in  = '0;
                  front_in = '0;
               end
               default: begin
               end
            endcase
         end

         ST_READ: begin
            best_in  = rd_data_ff;
            state_in = ST_DONE;
         end

         ST_SCAN: begin
            // Issue the next read while the previous entry is compared
            if (issue_idx_ff < held_ff) begin
               mem_re       = 1'b1;
               mem_raddr    = scan_addr_ff;
               scan_addr_in = (scan_addr_ff == LAST_ADDR) ? '0 : scan_addr_ff + 1'b1;
               issue_idx_in = issue_idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_idx_ff;
            end
            if (cmp_valid_ff) begin
               unique case (cmd_ff)
                  CMD_FIND: begin
                     if (cmp_res.eq) begin
                        res_pos_in = cmp_idx_ff[PW-1:0];
                        status_in  = STS_OK;
                        state_in   = ST_DONE;
                     end
                  end
                  CMD_COUNT: begin
                     if (cmp_res.eq) count_in = count_ff + 1'b1;
                  end
                  CMD_MIN: take_best = (cmp_idx_ff == '0) || cmp_res.lt;
                  default: take_best = (cmp_idx_ff == '0) || cmp_res.gt;
               endcase
               if (take_best) begin
                  best_in    = rd_data_ff;
                  res_pos_in = cmp_idx_ff[PW-1:0];
               end
               if (cmp_idx_ff == held_ff - 1'b1) state_in = ST_DONE;
               if (state_in == ST_DONE) cmp_valid_in = 1'b0;
            end
         end

         ST_DONE: begin
            // Move the result into the output register once it is free
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in  = 1'b1;
               out_value_in  = wide_value[31:0];
               out_pos_in    = 4'(res_pos_ff);
               out_count_in  = 5'(count_ff);
               out_occ_in    = 5'(held_ff);
               out_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         held_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         held_ff      <= held_in;
         cmp_valid_ff <= cmp_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      query_ff      <= query_in;
      pos_ff        <= pos_in;
      scan_addr_ff  <= scan_addr_in;
      issue_idx_ff  <= issue_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_ff       <= best_in;
      res_pos_ff    <= res_pos_in;
      count_ff      <= count_in;
      status_ff     <= status_in;
      out_value_ff  <= out_value_in;
      out_pos_ff    <= out_pos_in;
      out_count_ff  <= out_count_in;
      out_occ_ff    <= out_occ_in;
      out_status_ff <= out_status_in;
   end

   // Result channel
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.result_value    = out_value_ff;
   assign rsp_ch.result_position = out_pos_ff;
   assign rsp_ch.match_count     = out_count_ff;
   assign rsp_ch.occupancy       = out_occ_ff;
   assign rsp_ch.status          = out_status_ff;

endmodule

[tb/sv/tb_bounded_deque_with_search_top.sv]
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_top;
   import bdqs_pkg::*;

   // Codes the block leaves unused
   localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
   localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

   localparam int DEQUE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 700;
   localparam int CALM_ITEMS    = 100;
   localparam int LONG_HOLD_AT  = 150;
   localparam int LONG_HOLD     = 200;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_LIMIT  = 10;

   // Random phase mix
   localparam int TREND_GROW   = 0;
   localparam int TREND_SHRINK = 1;
   localparam int TREND_MIXED  = 2;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         position;
      logic [4:0]         hits;
      logic [4:0]         occupancy;
      logic [2:0]         status;
   } deque_result_type;

   // Tracks the ring contents and holds the results still owed by the block
   class deque_tracker;
      logic signed [31:0] slots [DEQUE_DEPTH];
      bit [3:0]           head;
      int unsigned        held;
      deque_result_type   pending [$];
      int                 errors;

      function new();
         head   = '0;
         held   = 0;
         errors = 0;
      endfunction

      function bit [3:0] ring(int unsigned i);
         return head + 4'(i);
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function int failure_total();
         return errors + pending.size();
      endfunction

      // Apply one accepted command and queue its expected result
      function void note_command(logic [3:0] cmd, logic signed [31:0] val, logic [3:0] pos);
         deque_result_type r;
         int unsigned      i;
         int unsigned      best;
         r.value    = '0;
         r.position = '0;
         r.hits     = '0;
         r.status   = STS_OK;
         case (cmd)
            CMD_APPEND: begin
               if (held == DEQUE_DEPTH) r.status = STS_FULL;
               else begin
                  slots[ring(held)] = val;
                  held++;
               end
            end
            CMD_PREPEND: begin
               if (held == DEQUE_DEPTH) r.status = STS_FULL;
               else begin
                  head = head - 4'd1;
                  slots[head] = val;
                  held++;
               end
            end
            CMD_POP_LAST: begin
               if (held == 0) r.status = STS_EMPTY;
               else begin
                  r.value = slots[ring(held - 1)];
                  held--;
               end
            end
            CMD_POP_FIRST: begin
               if (held == 0) r.status = STS_EMPTY;
               else begin
                  r.value = slots[head];
                  head = head + 4'd1;
                  held--;
               end
            end
            CMD_GET: begin
               if (held == 0) r.status = STS_EMPTY;
               else if (pos >= held) r.status = STS_RANGE;
               else r.value = slots[ring(pos)];
            end
            CMD_FIND: begin
               r.status = STS_NOT_FOUND;
               for (i = 0; i < held; i++) begin
                  if (slots[ring(i)] == val) begin
                     r.position = 4'(i);
                     r.status   = STS_OK;
                     break;
                  end
               end
            end
            CMD_COUNT: begin
               for (i = 0; i < held; i++)
                  if (slots[ring(i)] == val) r.hits = r.hits + 5'd1;
            end
            CMD_MIN, CMD_MAX: begin
               if (held == 0) r.status = STS_EMPTY;
               else begin
                  // first extreme from the front wins ties
                  best = 0;
                  for (i = 1; i < held; i++) begin
                     if (cmd == CMD_MIN ? (slots[ring(i)] < slots[ring(best)])
                                        : (slots[ring(i)] > slots[ring(best)]))
                        best = i;
                  end
                  r.value    = slots[ring(best)];
                  r.position = 4'(best);
               end
            end
            CMD_CLEAR: begin
               held = 0;
               head = '0;
            end
            default: ;
         endcase
         r.occupancy = 5'(held);
         pending.push_back(r);
      endfunction

      // Compare one result transfer against the oldest expectation
      function void check_result(deque_result_type got);
         deque_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("[%0t] unexpected result: value=%0d pos=%0d count=%0d occ=%0d status=%0d",
                        $realtime, got.value, got.position, got.hits, got.occupancy,
                        got.status);
            return;
         end
         want = pending.pop_front();
         if (got.value !== want.value || got.position !== want.position ||
             got.hits !== want.hits || got.occupancy !== want.occupancy ||
             got.status !== want.status) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("[%0t] result mismatch", $realtime);
               $display("   expected: value=%0d pos=%0d count=%0d occ=%0d status=%0d",
                        want.value, want.position, want.hits, want.occupancy, want.status);
               $display("   actual:   value=%0d pos=%0d count=%0d occ=%0d status=%0d",
                        got.value, got.position, got.hits, got.occupancy, got.status);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bdqs_req_if req_ch ();
   bdqs_rsp_if rsp_ch ();

   deque_tracker tracker = new();

   int          commands_accepted = 0;
   int          idle_cycles       = 0;
   bit          calm              = 1'b0;
   int unsigned send_gap_pct      = 10;

   logic signed [31:0] recent [DEQUE_DEPTH];
   int                 recent_at = 0;

   bounded_deque_with_search_top #(
      .DEPTH      (DEQUE_DEPTH),
      .DATA_WIDTH (32)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Observe transfers on both channels
   always @(posedge clock) begin : monitor
      deque_result_type got;
      if (!reset) begin
         idle_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_command(req_ch.command, req_ch.value, req_ch.position);
            commands_accepted++;
            idle_cycles = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.value     = rsp_ch.result_value;
            got.position  = rsp_ch.result_position;
            got.hits      = rsp_ch.match_count;
            got.occupancy = rsp_ch.occupancy;
            got.status    = rsp_ch.status;
            tracker.check_result(got);
            idle_cycles = 0;
         end
      end
   end

   // Hang detection: too long without any transfer
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: random stalls, one long hold-off, always ready at the end
   initial begin : receiver
      int  stall;
      int  mode_cycles;
      int  stall_pct;
      bit  long_hold_done;
      rsp_ch.ready <= 1'b0;
      mode_cycles    = 0;
      stall_pct      = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_cycles == 0) begin
            mode_cycles = 64;
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 35;
            endcase
         end
         mode_cycles--;
         stall = 0;
         if (!long_hold_done && commands_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            stall = LONG_HOLD;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall = $urandom_range(1, 10);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offer one command and hold it until the transfer
   task automatic issue(input logic [3:0] cmd, input logic signed [31:0] val,
                        input logic [3:0] pos);
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.value    <= val;
      req_ch.position <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic [3:0] choose_command(int trend);
      int pick;
      int ins;
      int pops;
      pick = $urandom_range(0, 99);
      case (trend)
         TREND_GROW:   begin ins = 65; pops = 10; end
         TREND_SHRINK: begin ins = 15; pops = 50; end
         default:      begin ins = 35; pops = 25; end
      endcase
      if (pick < ins) return $urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND;
      if (pick < ins + pops) return $urandom_range(0, 1) ? CMD_POP_LAST : CMD_POP_FIRST;
      if (pick < 96) begin
         case ($urandom_range(0, 4))
            0: return CMD_GET;
            1: return CMD_FIND;
            2: return CMD_COUNT;
            3: return CMD_MIN;
            default: return CMD_MAX;
         endcase
      end
      if (pick < 99) return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      return CMD_CLEAR;
   endfunction

   // Empty store, field extremes, ties, range edges, unused codes, clear
   task automatic run_directed();
      issue(CMD_POP_LAST, 32'sd0, 4'd0);
      issue(CMD_POP_FIRST, 32'sd0, 4'd0);
      issue(CMD_GET, 32'sd0, 4'd0);
      issue(CMD_FIND, 32'sd0, 4'd0);
      issue(CMD_COUNT, 32'sd0, 4'd0);
      issue(CMD_MIN, 32'sd0, 4'd0);
      issue(CMD_MAX, 32'sd0, 4'd0);
      issue(CMD_APPEND, 32'sh7FFF_FFFF, 4'd0);
      issue(CMD_PREPEND, 32'sh8000_0000, 4'd15);
      issue(CMD_APPEND, -32'sd1, 4'd0);
      issue(CMD_PREPEND, -32'sd1, 4'd0);
      issue(CMD_GET, 32'sd0, 4'd3);
      issue(CMD_GET, 32'sd0, 4'd4);
      issue(CMD_GET, 32'sd0, 4'd15);
      issue(CMD_FIND, -32'sd1, 4'd0);
      issue(CMD_FIND, 32'sh1234_5678, 4'd0);
      issue(CMD_COUNT, -32'sd1, 4'd0);
      issue(CMD_MIN, 32'sd0, 4'd0);
      issue(CMD_MAX, 32'sd0, 4'd0);
      issue(CMD_UNUSED_LO, 32'sh5A5A_5A5A, 4'd9);
      issue(CMD_UNUSED_HI, -32'sd1, 4'd15);
      issue(CMD_POP_LAST, 32'sd0, 4'd0);
      issue(CMD_POP_FIRST, 32'sd0, 4'd0);
      issue(CMD_CLEAR, 32'sd0, 4'd0);
      issue(CMD_GET, 32'sd0, 4'd0);
   endtask

   // Phases that grow, shrink or mix, with searches aimed at stored values
   task automatic run_random(int total);
      int                 n;
      int                 trend;
      int                 trend_left;
      logic [3:0]         cmd;
      logic signed [31:0] val;
      logic [3:0]         pos;
      trend      = TREND_GROW;
      trend_left = 0;
      for (n = 0; n < total; n++) begin
         calm = (n >= total - CALM_ITEMS);
         // sender pause until the block has answered everything
         if (n == total / 2) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (tracker.outstanding() != 0);
         end
         if (trend_left == 0) begin
            trend      = $urandom_range(TREND_GROW, TREND_MIXED);
            trend_left = $urandom_range(15, 40);
            case ($urandom_range(0, 2))
               0: send_gap_pct = 0;
               1: send_gap_pct = 10;
               default: send_gap_pct = 35;
            endcase
         end
         trend_left--;
         cmd = choose_command(trend);
         pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
         if ((cmd == CMD_FIND || cmd == CMD_COUNT) && $urandom_range(0, 1))
            val = recent[$urandom_range(0, DEQUE_DEPTH - 1)];
         else
            val = random_value();
         if (cmd == CMD_APPEND || cmd == CMD_PREPEND) begin
            recent[recent_at] = val;
            recent_at = (recent_at + 1) % DEQUE_DEPTH;
         end
         issue(cmd, val, pos);
      end
   endtask

   initial begin : stimulus
      int k;
      for (k = 0; k < DEQUE_DEPTH; k++) recent[k] = '0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.command  <= CMD_APPEND;
      req_ch.value    <= '0;
      req_ch.position <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(RANDOM_ITEMS);
      req_ch.valid <= 1'b0;

      // drain, then allow for any stray result
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.failure_total() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
